@@ sv/rzn_pkg.sv @@
// shared constants and types for the row z-score normalizer
`default_nettype none

package rzn_pkg;

  // row geometry
  localparam int ROW_LEN = 32;
  localparam int X_W     = 16;
  localparam int ADDR_W  = $clog2(ROW_LEN);
  localparam int CNT_W   = $clog2(ROW_LEN + 1);
  localparam int MEM_AW  = ADDR_W + 1;

  // datapath widths
  localparam int SUM_W   = X_W + CNT_W;
  localparam int D_W     = SUM_W + 1;
  localparam int MAG_W   = D_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int T_W     = SQ_W + CNT_W;
  localparam int P_W     = SQ_W + CNT_W;
  localparam int FRAC_SH = 26;
  localparam int Q_W     = 2 * ((CNT_W + FRAC_SH + 1) / 2);
  localparam int S_W     = Q_W / 2;
  localparam int Z_W     = 16;
  localparam int ZPOS_MAX = 2 ** (Z_W - 1) - 1;
  localparam int ZNEG_MAG = 2 ** (Z_W - 1);

  // row buffer write port
  typedef struct packed {
    logic                     en;
    logic [MEM_AW-1:0]        addr;
    logic signed [X_W-1:0]    data;
  } wr_t;

  // one finished row handed from the front to the back
  typedef struct packed {
    logic                     bank;
    logic [CNT_W-1:0]         n;
    logic signed [SUM_W-1:0]  sum;
  } row_desc_t;

endpackage

`default_nettype wire

@@ sv/rzn_front.sv @@
// front end: accepts samples, fills the row buffer, tracks count and sum
`default_nettype none

module rzn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [rzn_pkg::X_W-1:0] in_sample,
  input  logic                           in_row_end,
  input  logic                           row_free,
  output rzn_pkg::wr_t                   wr,
  output logic                           push,
  output rzn_pkg::row_desc_t             push_desc
);
  import rzn_pkg::*;

  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    bank_r, bank_nxt;
  logic [1:0]              rows_r, rows_nxt;
  logic                    accept;
  logic                    store;
  logic [CNT_W-1:0]        n_new;
  logic signed [SUM_W-1:0] s_new;

  // two row banks: stall while both hold rows not yet emitted
  assign in_stall = (rows_r == 2'd2);

  always_comb begin
    accept = in_valid && !in_stall;
    store  = accept && (fill_r < CNT_W'(ROW_LEN));
    n_new  = store ? fill_r + 1'b1 : fill_r;
    s_new  = store ? sum_r + {{(SUM_W - X_W){in_sample[X_W-1]}}, in_sample} : sum_r;

    wr.en   = store;
    wr.addr = {bank_r, fill_r[ADDR_W-1:0]};
    wr.data = in_sample;

    push           = accept && in_row_end;
    push_desc.bank = bank_r;
    push_desc.n    = n_new;
    push_desc.sum  = s_new;

    fill_nxt = n_new;
    sum_nxt  = s_new;
    bank_nxt = bank_r;
    if (push) begin
      fill_nxt = '0;
      sum_nxt  = '0;
      bank_nxt = !bank_r;
    end

    // rows in flight between the two sides
    case ({push, row_free})
      2'b10:   rows_nxt = rows_r + 2'd1;
      2'b01:   rows_nxt = rows_r - 2'd1;
      default: rows_nxt = rows_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
      bank_r <= 1'b0;
      rows_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      bank_r <= bank_nxt;
      rows_r <= rows_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !(row_free && rows_r == 2'd0) && !(push && rows_r == 2'd2))
    else $error("row credit out of range");
`endif

endmodule

`default_nettype wire

@@ sv/rzn_queue.sv @@
// two-entry queue of finished row descriptors
`default_nettype none

module rzn_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rzn_pkg::row_desc_t  push_desc,
  input  logic                pop,
  output logic                q_valid,
  output rzn_pkg::row_desc_t  q_desc
);
  import rzn_pkg::*;

  row_desc_t  ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != 2'd0);
  assign q_desc  = ent_r[rptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2) && !(pop && cnt_r == 2'd0))
    else $error("row queue overflow or underflow");
`endif

endmodule

`default_nettype wire

@@ sv/rzn_zunit.sv @@
// serial z magnitude unit: restoring divide, then digit-by-digit square root
`default_nettype none

module rzn_zunit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rzn_pkg::P_W-1:0]     p_in,
  input  logic [rzn_pkg::T_W-1:0]     t_in,
  output logic                        done,
  output logic [rzn_pkg::S_W-1:0]     k
);
  import rzn_pkg::*;

  localparam int CW = $clog2(Q_W);

  typedef enum logic [3:0] {
    Z_IDLE = 4'b0001,
    Z_DIV  = 4'b0010,
    Z_SQRT = 4'b0100,
    Z_DONE = 4'b1000
  } zst_t;

  zst_t             st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [T_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]   low_r, low_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [S_W:0]     srem_r, srem_nxt;
  logic [S_W-1:0]   root_r, root_nxt;
  logic [T_W:0]     trial;
  logic             ge;
  logic [S_W+1:0]   srem_sh;
  logic [S_W+1:0]   trial2;
  logic             ge2;
  logic [S_W:0]     kw;

  // k = (isqrt(q) + 1) / 2
  assign kw   = {1'b0, root_r} + 1'b1;
  assign k    = kw[S_W:1];
  assign done = (st_r == Z_DONE);

  always_comb begin
    trial   = {rem_r, low_r[Q_W-1]};
    ge      = (trial >= {1'b0, t_r});
    srem_sh = {srem_r[S_W-1:0], low_r[Q_W-1:Q_W-2]};
    trial2  = {root_r, 2'b01};
    ge2     = (srem_sh >= trial2);

    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    t_nxt    = t_r;
    srem_nxt = srem_r;
    root_nxt = root_r;

    case (st_r)
      Z_IDLE: begin
        if (start) begin
          // dividend is p * 2^26, its top part already below t
          rem_nxt = T_W'(p_in >> (Q_W - FRAC_SH));
          low_nxt = {p_in[Q_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
          t_nxt   = t_in;
          cnt_nxt = '0;
          st_nxt  = Z_DIV;
        end
      end
      Z_DIV: begin
        // one quotient bit per cycle
        rem_nxt = ge ? T_W'(trial - {1'b0, t_r}) : trial[T_W-1:0];
        low_nxt = {low_r[Q_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(Q_W - 1)) begin
          cnt_nxt  = '0;
          srem_nxt = '0;
          root_nxt = '0;
          st_nxt   = Z_SQRT;
        end
      end
      Z_SQRT: begin
        // one root bit per cycle
        srem_nxt = ge2 ? (S_W+1)'(srem_sh - trial2) : (S_W+1)'(srem_sh);
        root_nxt = {root_r[S_W-2:0], ge2};
        low_nxt  = {low_r[Q_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(S_W - 1)) begin
          st_nxt = Z_DONE;
        end
      end
      Z_DONE: begin
        st_nxt = Z_IDLE;
      end
      default: begin
        st_nxt = Z_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= Z_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    t_r    <= t_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == Z_IDLE)
    else $error("z unit started while busy");
`endif

endmodule

`default_nettype wire

@@ sv/rzn_back.sv @@
// back end: row buffer, sum of squares pass, per-element z-score and output register
`default_nettype none

module rzn_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rzn_pkg::wr_t                   wr,
  input  logic                           q_valid,
  input  rzn_pkg::row_desc_t             q_desc,
  output logic                           pop,
  output logic                           row_free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [rzn_pkg::Z_W-1:0] out_zscore,
  output logic                           out_zero_spread,
  output logic                           out_short_row,
  output logic                           out_last_out
);
  import rzn_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_DIF  = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ZGO  = 9'b001000000,
    S_ZRUN = 9'b010000000,
    S_OUT  = 9'b100000000
  } bst_t;

  logic signed [X_W-1:0]   mem [2**MEM_AW];
  logic signed [X_W-1:0]   rdata_r;

  bst_t                    st_r, st_nxt;
  logic                    bank_r, bank_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [SUM_W-1:0] s_r, s_nxt;
  logic [ADDR_W-1:0]       idx_r, idx_nxt;
  logic                    pass_r, pass_nxt;
  logic signed [D_W-1:0]   d_r, d_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [T_W-1:0]          t_r, t_nxt;
  logic [P_W-1:0]          p_r, p_nxt;
  logic [Z_W-1:0]          z_r, z_nxt;
  logic                    zsp_r, zsp_nxt;
  logic                    short_r, short_nxt;
  logic                    last_r, last_nxt;

  logic signed [D_W-1:0]   nx;
  logic [MAG_W-1:0]        mag;
  logic [CNT_W-1:0]        nm1;
  logic                    last_el;
  logic                    z_start;
  logic                    z_done;
  logic [S_W-1:0]          z_k;

  // row buffer, both banks
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[{bank_r, idx_r}];
  end

  rzn_zunit u_zunit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (z_start),
    .p_in  (p_r),
    .t_in  (t_r),
    .done  (z_done),
    .k     (z_k)
  );

  assign out_valid       = (st_r == S_OUT);
  assign out_zscore      = z_r;
  assign out_zero_spread = zsp_r;
  assign out_short_row   = short_r;
  assign out_last_out    = last_r;
  assign z_start         = (st_r == S_ZGO);

  always_comb begin
    nx      = $signed({1'b0, n_r}) * rdata_r;
    mag     = d_r[D_W-1] ? MAG_W'(-d_r) : MAG_W'(d_r);
    nm1     = n_r - 1'b1;
    last_el = ((CNT_W'(idx_r) + 1'b1) == n_r);

    st_nxt    = st_r;
    bank_nxt  = bank_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    z_nxt     = z_r;
    zsp_nxt   = zsp_r;
    short_nxt = short_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    row_free  = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          bank_nxt = q_desc.bank;
          n_nxt    = q_desc.n;
          s_nxt    = q_desc.sum;
          idx_nxt  = '0;
          pass_nxt = 1'b0;
          t_nxt    = '0;
          if (q_desc.n < CNT_W'(2)) begin
            // single-sample row
            z_nxt     = '0;
            zsp_nxt   = 1'b0;
            short_nxt = 1'b1;
            last_nxt  = 1'b1;
            st_nxt    = S_OUT;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        st_nxt = S_DIF;
      end
      S_DIF: begin
        // d = n*x - sum
        d_nxt  = nx - {{(D_W - SUM_W){s_r[SUM_W-1]}}, s_r};
        st_nxt = S_SQ;
      end
      S_SQ: begin
        sq_nxt = mag * mag;
        if (!pass_r) begin
          st_nxt = S_ACC;
        end else if (t_r == '0) begin
          // all samples equal
          z_nxt     = '0;
          zsp_nxt   = 1'b1;
          short_nxt = 1'b0;
          last_nxt  = last_el;
          st_nxt    = S_OUT;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_ACC: begin
        t_nxt  = t_r + T_W'(sq_r);
        st_nxt = S_RD;
        if (last_el) begin
          idx_nxt  = '0;
          pass_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MUL: begin
        p_nxt  = sq_r * nm1;
        st_nxt = S_ZGO;
      end
      S_ZGO: begin
        st_nxt = S_ZRUN;
      end
      S_ZRUN: begin
        if (z_done) begin
          // sign and saturation to q4.12
          if (d_r[D_W-1]) begin
            z_nxt = (z_k > S_W'(ZNEG_MAG)) ? Z_W'(ZNEG_MAG) : Z_W'(S_W'(0) - z_k);
          end else begin
            z_nxt = (z_k > S_W'(ZPOS_MAX)) ? Z_W'(ZPOS_MAX) : Z_W'(z_k);
          end
          zsp_nxt   = 1'b0;
          short_nxt = 1'b0;
          last_nxt  = last_el;
          st_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last_r) begin
            row_free = 1'b1;
            st_nxt   = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = S_RD;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r  <= bank_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    idx_r   <= idx_nxt;
    pass_r  <= pass_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    t_r     <= t_nxt;
    p_r     <= p_nxt;
    z_r     <= z_nxt;
    zsp_r   <= zsp_nxt;
    short_r <= short_nxt;
    last_r  <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_zero_spread || out_short_row) |-> out_zscore == '0)
    else $error("flagged word carries nonzero zscore");

  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_row |-> out_last_out && !out_zero_spread)
    else $error("short row word not marked last");
`endif

endmodule

`default_nettype wire

@@ sv/row_z_score_normalizer_top.sv @@
// top level of the row z-score normalizer
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_sample, in_row_end
//   out     | out | out_valid/out_stall | out_zscore, out_zero_spread,
//           |     |                    | out_short_row, out_last_out
//
// loading takes one sample per cycle while in_stall is low; a row of n
// samples then takes a sum of squares pass and a per-element pass set by the
// serial divide (32 steps) and square root (16 steps) unit, and each
// output word may wait under out_stall.
// two row banks let the next row load while the current one is emitted;
// the input stalls only while both banks hold rows not yet fully emitted.
// reset is synchronous, active low, and clears all control state.
`default_nettype none

module row_z_score_normalizer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [rzn_pkg::X_W-1:0] in_sample,
  input  logic                           in_row_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [rzn_pkg::Z_W-1:0] out_zscore,
  output logic                           out_zero_spread,
  output logic                           out_short_row,
  output logic                           out_last_out
);
  import rzn_pkg::*;

  wr_t       wr;
  logic      push;
  row_desc_t push_desc;
  logic      pop;
  logic      q_valid;
  row_desc_t q_desc;
  logic      row_free;

  // sample intake
  rzn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .in_row_end (in_row_end),
    .row_free   (row_free),
    .wr         (wr),
    .push       (push),
    .push_desc  (push_desc)
  );

  // finished rows waiting for the back end
  rzn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  // normalization and output
  rzn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr              (wr),
    .q_valid         (q_valid),
    .q_desc          (q_desc),
    .pop             (pop),
    .row_free        (row_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_zscore      (out_zscore),
    .out_zero_spread (out_zero_spread),
    .out_short_row   (out_short_row),
    .out_last_out    (out_last_out)
  );

endmodule

`default_nettype wire

@@ test/row_z_score_normalizer_checker.sv @@
// channel monitor, z-score predictor and result comparator for the row normalizer
module row_z_score_normalizer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [rzn_pkg::X_W-1:0] in_sample,
  input  logic                           in_row_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [rzn_pkg::Z_W-1:0] out_zscore,
  input  logic                           out_zero_spread,
  input  logic                           out_short_row,
  input  logic                           out_last_out,
  output int                             failures,
  output int                             pending
);
  import rzn_pkg::*;

  typedef struct {
    logic [Z_W-1:0] zscore;
    logic           zero_spread;
    logic           short_row;
    logic           last_out;
  } zword_t;

  zword_t zscore_q[$];

  // model copy of the row buffer
  longint row_buf[ROW_LEN];
  int     row_fill;
  longint row_sum;

  initial pending = 0;

  // rounded magnitude of |d| * 4096 * sqrt((n-1)/t), capped at 32768
  function automatic int unsigned scaled_mag(longint unsigned dmag, longint unsigned nm1,
                                             longint unsigned t);
    longint unsigned rhs;
    logic [127:0]    lhs_p, rhs_p;
    int unsigned     lo, hi, mid;
    longint unsigned q;
    rhs = dmag * dmag * 4 * nm1;
    rhs_p = 128'(rhs) << 24;
    lo = 0;
    hi = ZNEG_MAG;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      q = 2 * longint'(mid) - 1;
      lhs_p = 128'(q * q) * 128'(t);
      if (lhs_p <= rhs_p) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // store one word; at the row end queue the normalized row
  task automatic load_word(logic signed [X_W-1:0] x, logic row_end);
    int              n;
    longint          d;
    longint unsigned dmag, t;
    int unsigned     k;
    zword_t          w;
    if (row_fill < ROW_LEN) begin
      row_buf[row_fill] = longint'(x);
      row_fill++;
      row_sum += longint'(x);
    end
    if (!row_end) return;
    n = row_fill;
    row_fill = 0;
    // sum of squared scaled deviations
    t = 0;
    for (int i = 0; i < n; i++) begin
      d = n * row_buf[i] - row_sum;
      dmag = (d < 0) ? -d : d;
      t += dmag * dmag;
    end
    for (int i = 0; i < n; i++) begin
      w.zscore = '0;
      w.zero_spread = 1'b0;
      w.short_row = (n < 2);
      w.last_out = (i == n - 1);
      if (n >= 2) begin
        if (t == 0) begin
          w.zero_spread = 1'b1;
        end else begin
          d = n * row_buf[i] - row_sum;
          dmag = (d < 0) ? -d : d;
          k = scaled_mag(dmag, n - 1, t);
          if (d < 0) w.zscore = Z_W'(32'h10000 - k);
          else w.zscore = (k > ZPOS_MAX) ? Z_W'(ZPOS_MAX) : Z_W'(k);
        end
      end
      zscore_q.push_back(w);
    end
    row_sum = 0;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    zword_t w;
    if (!rst_n) begin
      row_fill <= 0;
      row_sum <= 0;
      failures <= 0;
    end else begin
      if (in_valid && !in_stall) load_word(in_sample, in_row_end);
      if (out_valid && !out_stall) begin
        if (zscore_q.size() == 0) begin
          $error("unexpected output word zscore=%0d", out_zscore);
          failures++;
        end else begin
          w = zscore_q.pop_front();
          if (out_zscore !== w.zscore) begin
            $error("zscore expected %0d got %0d", $signed(w.zscore), out_zscore);
            failures++;
          end
          if (out_zero_spread !== w.zero_spread) begin
            $error("zero_spread expected %0b got %0b", w.zero_spread, out_zero_spread);
            failures++;
          end
          if (out_short_row !== w.short_row) begin
            $error("short_row expected %0b got %0b", w.short_row, out_short_row);
            failures++;
          end
          if (out_last_out !== w.last_out) begin
            $error("last_out expected %0b got %0b", w.last_out, out_last_out);
            failures++;
          end
        end
      end
    end
    pending <= zscore_q.size();
  end

endmodule

@@ test/row_z_score_normalizer_top_tb.sv @@
// stimulus and verdict for the row z-score normalizer
module row_z_score_normalizer_top_tb;
  import rzn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [X_W-1:0] in_sample = '0;
  logic                  in_row_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [Z_W-1:0] out_zscore;
  logic                  out_zero_spread;
  logic                  out_short_row;
  logic                  out_last_out;
  int                    failures;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    cycle_cnt = 0;

  row_z_score_normalizer_top uut (.*);

  row_z_score_normalizer_checker chk (.*);

  always #10 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one word and hold it until accepted
  task automatic send_word(logic signed [X_W-1:0] x, logic row_end);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    in_row_end <= row_end;
    // stall is taken as it stood just before the edge
    @(posedge clk iff !in_stall);
  endtask

  // one row of random samples, optionally all equal or narrow
  task automatic send_row(int len);
    logic signed [X_W-1:0] base;
    int                    kind;
    base = X_W'($urandom);
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) send_word(base, i == len - 1);
      else if (kind == 1) send_word(base + $signed(X_W'($urandom_range(3))), i == len - 1);
      else send_word(X_W'($urandom), i == len - 1);
    end
  endtask

  initial begin
    int len;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    // directed rows
    send_word(16'sh1234, 1'b1);
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd5, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b1);
    send_word(-16'sh8000, 1'b0);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b1);
    send_word(16'sd0, 1'b0);
    send_word(16'sd256, 1'b0);
    send_word(-16'sd256, 1'b0);
    send_word(16'sd1, 1'b1);
    // random rows in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 8 : 0;
      for (int cnt = 0; cnt < 110; cnt += len) begin
        case ($urandom_range(19))
          0:       len = 1;
          1:       len = ROW_LEN;
          2:       len = ROW_LEN + $urandom_range(1, 8);
          default: len = $urandom_range(2, 10);
        endcase
        send_row(len);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (failures == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
